>>> hw/rtl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int DEF_MAX_PAGES  = 4096;
   localparam int DEF_NUM_ORDERS = 11;
   localparam int ORDER_W        = 4;
   localparam int PAGE_W         = 36;
   localparam int RPAGES_W       = 13;
   localparam int STATUS_W       = 2;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_FREE    = 2'd2,
      OP_RESERVE = 2'd3
   } op_type;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

   typedef enum logic {
      CSR_BASE  = 1'b0,
      CSR_PAGES = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      BK_TEST,
      BK_USED,
      BK_FREE
   } bitop_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT_FILL,
      S_INIT_TAIL,
      S_INIT_TOP,
      S_A_FIND,
      S_A_SPLIT,
      S_LOCATE,
      S_F_TESTED,
      S_R_TESTED,
      S_ANC,
      S_ANC_CHK,
      S_F_DO,
      S_F_MERGE,
      S_F_M1,
      S_F_M2,
      S_F_M3,
      S_R_SPLIT,
      S_R_OK,
      S_BIT_RD,
      S_BIT_EX,
      S_SCAN,
      S_SCAN_RD,
      S_SCAN_EX,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/bpa_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 704
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/bpa_locate.sv
// Page number to block index translation with region and alignment checks.
`timescale 1ns / 1ps
module bpa_locate import bpa_pkg::*; #(
   parameter int MAX_PAGES = DEF_MAX_PAGES
) (
   input  logic [PAGE_W-1:0]                 page_number,
   input  logic [PAGE_W-1:0]                 base_page,
   input  logic [$clog2(MAX_PAGES+1)-1:0]    mapped_pages,
   input  logic [ORDER_W-1:0]                order,
   output logic                              loc_ok,
   output logic [$clog2(MAX_PAGES)-1:0]      loc_idx
);

   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int IW = $clog2(MAX_PAGES);

   logic [PAGE_W-1:0] offset;
   logic [PAGE_W-1:0] align_mask;
   logic [PAGE_W-1:0] blk;
   logic [CW-1:0]     len_k;
   logic              below, past_end, misaligned, runs_over;

   // offset into the region, then block index at this order
   always_comb begin
      offset     = page_number - base_page;
      below      = page_number < base_page;
      past_end   = offset >= PAGE_W'(mapped_pages);
      align_mask = ~({PAGE_W{1'b1}} << order);
      misaligned = |(offset & align_mask);
      blk        = offset >> order;
      len_k      = mapped_pages >> order;
      runs_over  = blk >= PAGE_W'(len_k);
      loc_ok     = !(below || past_end || misaligned || runs_over);
      loc_idx    = blk[IW-1:0];
   end

endmodule

>>> hw/rtl/buddy_page_allocator.sv
// Buddy page allocator top level: command sequencer around the bitmap RAM.
`timescale 1ns / 1ps
//
// Usage: set region_base_page (csr index 0) and region_pages (csr index 1)
// through the csr_ write port while idle, then issue an init beat
// (req_op = 0). Further beats allocate (1), free (2) or reserve (3) a
// block of 2^req_order pages. A beat is taken when start is high and busy
// is low; busy stays high up to and including the result cycle. The result
// shows for exactly one cycle with rsp_valid high; the receiver cannot stall it.
// Steps: every bitmap access is a read-modify-write of one bitmap word
// (64 bits at the defaults): the issuing state, a read state and an update
// state. Bad order: the result follows in the cycle after the beat is taken.
// Alloc: search upward from the requested order for a free block, take the
// hinted block, split down an order at a time freeing the upper buddy, then
// finish. Free: locate and test, test each ancestor up to the top order,
// release, then at each merge level test the buddy, take both halves and
// free the parent, up to a used buddy or the top order. Reserve: locate and
// test, test each ancestor walked, claim, then free a sibling per split
// level and finish. Every item but a bad order then rescans, from the old
// hint on, each order whose hint went stale, and then gives the result.
// Init first sweeps all NUM_ORDERS * WPO words to ones (704 at the
// defaults), then marks the tail and top-order blocks free.
// Reset clears the configuration and leaves nothing free until init.
//
module buddy_page_allocator import bpa_pkg::*; #(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int NUM_ORDERS = DEF_NUM_ORDERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic [ORDER_W-1:0]  req_order,
   input  logic [PAGE_W-1:0]   req_page_number,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_result_page,
   output logic [RPAGES_W-1:0] rsp_avail_pages,
   output logic                rsp_region_full,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [PAGE_W-1:0]   csr_wdata
);

   localparam int CW   = $clog2(MAX_PAGES + 1);
   localparam int IW   = $clog2(MAX_PAGES);
   localparam int WB   = (MAX_PAGES >= 128) ? 64 : MAX_PAGES / 2;
   localparam int WBL  = $clog2(WB);
   localparam int WPO  = MAX_PAGES / WB;
   localparam int WLW  = $clog2(WPO);
   localparam int OIW  = $clog2(NUM_ORDERS);
   localparam int DEPTH = NUM_ORDERS * WPO;
   localparam int AW   = $clog2(DEPTH);
   localparam int XW   = (CW > 16) ? CW : 16;
   localparam logic [ORDER_W-1:0] TOPK = ORDER_W'(NUM_ORDERS - 1);

   state_type          state_ff, state_in, ret_ff, ret_in;
   op_type             op_ff, op_in;
   bitop_type          kind_ff, kind_in;
   logic [ORDER_W-1:0] ord_ff, ord_in, k_ff, k_in, bk_ff, bk_in, sk_ff, sk_in;
   logic [PAGE_W-1:0]  pn_ff, pn_in, page_ff, page_in, base_ff;
   logic [IW-1:0]      idx_ff, idx_in, bi_ff, bi_in;
   logic               used_ff, used_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0]      total_ff, total_in, mapped_ff, mapped_in;
   logic [RPAGES_W-1:0] rpages_ff;
   logic [CW-1:0]      cnt_ff [NUM_ORDERS];
   logic [CW-1:0]      cnt_in [NUM_ORDERS];
   logic [IW-1:0]      hint_ff [NUM_ORDERS];
   logic [IW-1:0]      hint_in [NUM_ORDERS];
   logic [NUM_ORDERS-1:0] dirty_ff, dirty_in;
   logic [AW-1:0]      fill_ff, fill_in;
   logic [WLW-1:0]     sw_ff, sw_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [WB-1:0]      ram_wdata, ram_rdata;

   logic               loc_ok;
   logic [IW-1:0]      loc_idx;

   logic [OIW-1:0]     dsel;
   logic               dany;
   logic [WBL-1:0]     fpos;
   logic               fany;
   logic [CW-1:0]      len_sk;

   // bitmap store, one region of WPO words per order
   bpa_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bpa_locate #(.MAX_PAGES(MAX_PAGES)) u_locate (
      .page_number  (pn_ff),
      .base_page    (base_ff),
      .mapped_pages (mapped_ff),
      .order        (ord_ff),
      .loc_ok       (loc_ok),
      .loc_idx      (loc_idx)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         rpages_ff <= '0;
      end else if (csr_we) begin
         if (csr_type'(csr_index) == CSR_BASE) begin
            base_ff <= csr_wdata;
         end else begin
            rpages_ff <= csr_wdata[RPAGES_W-1:0];
         end
      end
   end

   // lowest order with a stale hint
   always_comb begin
      dsel = '0;
      dany = 1'b0;
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         if (dirty_ff[i]) begin
            dsel = OIW'(i);
            dany = 1'b1;
         end
      end
   end

   // lowest free in-range bit of the scanned word
   always_comb begin
      len_sk = mapped_ff >> sk_ff;
      fpos   = '0;
      fany   = 1'b0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (!ram_rdata[b] && ({1'b0, sw_ff, WBL'(b)} < len_sk)) begin
            fpos = WBL'(b);
            fany = 1'b1;
         end
      end
   end

   // sequencer: next state and datapath updates
   always_comb begin
      logic [OIW-1:0]    tidx;
      logic [CW-1:0]     mk, lenb, sat;
      logic [XW-1:0]     blkp, tot, room;
      logic [WB-1:0]     onehot;
      logic              inr, bitv, usedb;
      logic [ORDER_W-1:0] sh;

      state_in  = state_ff;
      ret_in    = ret_ff;
      op_in     = op_ff;
      kind_in   = kind_ff;
      ord_in    = ord_ff;
      k_in      = k_ff;
      bk_in     = bk_ff;
      sk_in     = sk_ff;
      pn_in     = pn_ff;
      page_in   = page_ff;
      idx_in    = idx_ff;
      bi_in     = bi_ff;
      used_in   = used_ff;
      status_in = status_ff;
      total_in  = total_ff;
      mapped_in = mapped_ff;
      cnt_in    = cnt_ff;
      hint_in   = hint_ff;
      dirty_in  = dirty_ff;
      fill_in   = fill_ff;
      sw_in     = sw_ff;

      ram_we    = 1'b0;
      ram_waddr = {bk_ff[OIW-1:0], bi_ff[IW-1:WBL]};
      ram_wdata = '1;
      ram_raddr = {bk_ff[OIW-1:0], bi_ff[IW-1:WBL]};
      tidx      = k_ff[OIW-1:0];

      mk     = mapped_ff >> k_ff;
      lenb   = mapped_ff >> bk_ff;
      sat    = (int'(rpages_ff) > MAX_PAGES) ? CW'(MAX_PAGES) : CW'(rpages_ff);
      blkp   = XW'(1) << ord_ff;
      tot    = XW'(total_ff);
      room   = XW'(mapped_ff) - tot;
      onehot = WB'(1) << bi_ff[WBL-1:0];
      inr    = {1'b0, bi_ff} < lenb;
      bitv   = ram_rdata[bi_ff[WBL-1:0]];
      usedb  = !inr || bitv;
      sh     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = op_type'(req_op);
               ord_in    = req_order;
               pn_in     = req_page_number;
               status_in = ST_OK;
               page_in   = '0;
               if (op_type'(req_op) == OP_INIT) begin
                  fill_in   = '0;
                  mapped_in = sat;
                  total_in  = sat;
                  dirty_in  = '0;
                  for (int i = 0; i < NUM_ORDERS; i++) begin
                     cnt_in[i]  = '0;
                     hint_in[i] = '0;
                  end
                  state_in = S_INIT_FILL;
               end else if (int'(req_order) >= NUM_ORDERS) begin
                  status_in = ST_BAD_ORDER;
                  state_in  = S_DONE;
               end else if (op_type'(req_op) == OP_ALLOC) begin
                  k_in     = req_order;
                  state_in = S_A_FIND;
               end else begin
                  state_in = S_LOCATE;
               end
            end
         end

         // set every bitmap word to all used
         S_INIT_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = fill_ff;
            ram_wdata = '1;
            if (fill_ff == AW'(DEPTH - 1)) begin
               k_in     = '0;
               state_in = S_INIT_TAIL;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end

         // odd tail block at each lower order
         S_INIT_TAIL: begin
            if (k_ff == TOPK) begin
               idx_in   = '0;
               state_in = S_INIT_TOP;
            end else begin
               k_in = k_ff + 1'b1;
               if (mk[0]) begin
                  kind_in = BK_FREE; bk_in = k_ff; bi_in = IW'(mk - 1'b1);
                  ret_in = S_INIT_TAIL; state_in = S_BIT_RD;
               end
            end
         end

         // every block of the top order
         S_INIT_TOP: begin
            if ({1'b0, idx_ff} < (mapped_ff >> TOPK)) begin
               idx_in  = idx_ff + 1'b1;
               kind_in = BK_FREE; bk_in = TOPK; bi_in = idx_ff;
               ret_in = S_INIT_TOP; state_in = S_BIT_RD;
            end else begin
               state_in = S_SCAN;
            end
         end

         // smallest order with a free block
         S_A_FIND: begin
            if (cnt_ff[tidx] != '0) begin
               idx_in  = hint_ff[tidx];
               kind_in = BK_USED; bk_in = k_ff; bi_in = hint_ff[tidx];
               ret_in = S_A_SPLIT; state_in = S_BIT_RD;
            end else if (k_ff == TOPK) begin
               status_in = ST_NO_MEM;
               state_in  = S_SCAN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // split down, keep the lower half, free the upper buddy
         S_A_SPLIT: begin
            if (k_ff > ord_ff) begin
               k_in    = k_ff - 1'b1;
               idx_in  = {idx_ff[IW-2:0], 1'b0};
               kind_in = BK_FREE; bk_in = k_ff - 1'b1; bi_in = {idx_ff[IW-2:0], 1'b1};
               ret_in = S_A_SPLIT; state_in = S_BIT_RD;
            end else begin
               total_in = (blkp > tot) ? '0 : CW'(tot - blkp);
               page_in  = base_ff + (PAGE_W'(idx_ff) << ord_ff);
               state_in = S_SCAN;
            end
         end

         S_LOCATE: begin
            if (!loc_ok) begin
               status_in = ST_NOT_ALLOC;
               state_in  = S_SCAN;
            end else begin
               idx_in  = loc_idx;
               kind_in = BK_TEST; bk_in = ord_ff; bi_in = loc_idx;
               ret_in  = (op_ff == OP_FREE) ? S_F_TESTED : S_R_TESTED;
               state_in = S_BIT_RD;
            end
         end

         S_F_TESTED: begin
            if (!used_ff) begin
               status_in = ST_NOT_ALLOC;
               state_in  = S_SCAN;
            end else begin
               k_in     = ord_ff;
               state_in = S_ANC;
            end
         end

         S_R_TESTED: begin
            if (!used_ff) begin
               kind_in = BK_USED; bk_in = ord_ff; bi_in = idx_ff;
               ret_in = S_R_OK; state_in = S_BIT_RD;
            end else begin
               k_in     = ord_ff;
               state_in = S_ANC;
            end
         end

         // walk up looking for a free ancestor
         S_ANC: begin
            if (k_ff == TOPK) begin
               if (op_ff == OP_FREE) begin
                  state_in = S_F_DO;
               end else begin
                  status_in = ST_NOT_ALLOC;
                  state_in  = S_SCAN;
               end
            end else begin
               sh      = k_ff + 1'b1 - ord_ff;
               k_in    = k_ff + 1'b1;
               kind_in = BK_TEST; bk_in = k_ff + 1'b1; bi_in = idx_ff >> sh;
               ret_in = S_ANC_CHK; state_in = S_BIT_RD;
            end
         end

         S_ANC_CHK: begin
            if (used_ff) begin
               state_in = S_ANC;
            end else if (op_ff == OP_FREE) begin
               status_in = ST_NOT_ALLOC;
               state_in  = S_SCAN;
            end else begin
               sh      = k_ff - ord_ff;
               kind_in = BK_USED; bk_in = k_ff; bi_in = idx_ff >> sh;
               ret_in = S_R_SPLIT; state_in = S_BIT_RD;
            end
         end

         S_F_DO: begin
            total_in = (blkp > room) ? mapped_ff : CW'(tot + blkp);
            k_in     = ord_ff;
            kind_in  = BK_FREE; bk_in = ord_ff; bi_in = idx_ff;
            ret_in = S_F_MERGE; state_in = S_BIT_RD;
         end

         // merge with a free buddy, one order per pass
         S_F_MERGE: begin
            if (k_ff == TOPK) begin
               state_in = S_SCAN;
            end else begin
               kind_in = BK_TEST; bk_in = k_ff; bi_in = idx_ff ^ IW'(1);
               ret_in = S_F_M1; state_in = S_BIT_RD;
            end
         end

         S_F_M1: begin
            if (used_ff) begin
               state_in = S_SCAN;
            end else begin
               kind_in = BK_USED; bk_in = k_ff; bi_in = idx_ff;
               ret_in = S_F_M2; state_in = S_BIT_RD;
            end
         end

         S_F_M2: begin
            kind_in = BK_USED; bk_in = k_ff; bi_in = idx_ff ^ IW'(1);
            ret_in = S_F_M3; state_in = S_BIT_RD;
         end

         S_F_M3: begin
            k_in    = k_ff + 1'b1;
            idx_in  = idx_ff >> 1;
            kind_in = BK_FREE; bk_in = k_ff + 1'b1; bi_in = idx_ff >> 1;
            ret_in = S_F_MERGE; state_in = S_BIT_RD;
         end

         // free the sibling at each order below the claimed ancestor
         S_R_SPLIT: begin
            if (k_ff > ord_ff) begin
               sh      = k_ff - 1'b1 - ord_ff;
               k_in    = k_ff - 1'b1;
               kind_in = BK_FREE; bk_in = k_ff - 1'b1; bi_in = (idx_ff >> sh) ^ IW'(1);
               ret_in = S_R_SPLIT; state_in = S_BIT_RD;
            end else begin
               state_in = S_R_OK;
            end
         end

         S_R_OK: begin
            total_in = (blkp > tot) ? '0 : CW'(tot - blkp);
            page_in  = pn_ff;
            state_in = S_SCAN;
         end

         S_BIT_RD: begin
            state_in = S_BIT_EX;
         end

         // bit update: write back, keep count and hint in step
         S_BIT_EX: begin
            tidx    = bk_ff[OIW-1:0];
            used_in = usedb;
            if (kind_ff == BK_USED && !usedb) begin
               ram_we       = 1'b1;
               ram_wdata    = ram_rdata | onehot;
               cnt_in[tidx] = cnt_ff[tidx] - 1'b1;
               if (bi_ff == hint_ff[tidx]) begin
                  dirty_in[tidx] = 1'b1;
               end
            end else if (kind_ff == BK_FREE && inr && bitv) begin
               ram_we       = 1'b1;
               ram_wdata    = ram_rdata & ~onehot;
               cnt_in[tidx] = cnt_ff[tidx] + 1'b1;
               if (cnt_ff[tidx] == '0 || bi_ff < hint_ff[tidx]) begin
                  hint_in[tidx]  = bi_ff;
                  dirty_in[tidx] = 1'b0;
               end
            end
            state_in = ret_ff;
         end

         // refresh stale hints
         S_SCAN: begin
            tidx = dsel;
            if (!dany) begin
               state_in = S_DONE;
            end else if (cnt_ff[tidx] == '0) begin
               hint_in[tidx]  = '0;
               dirty_in[tidx] = 1'b0;
            end else begin
               sk_in    = ORDER_W'(dsel);
               sw_in    = hint_ff[tidx][IW-1:WBL];
               state_in = S_SCAN_RD;
            end
         end

         S_SCAN_RD: begin
            ram_raddr = {sk_ff[OIW-1:0], sw_ff};
            state_in  = S_SCAN_EX;
         end

         S_SCAN_EX: begin
            tidx = sk_ff[OIW-1:0];
            if (fany) begin
               hint_in[tidx]  = {sw_ff, fpos};
               dirty_in[tidx] = 1'b0;
               state_in       = S_SCAN;
            end else if (sw_ff == {WLW{1'b1}}) begin
               hint_in[tidx]  = '0;
               dirty_in[tidx] = 1'b0;
               state_in       = S_SCAN;
            end else begin
               sw_in    = sw_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         total_ff  <= '0;
         mapped_ff <= '0;
         dirty_ff  <= '0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            cnt_ff[i]  <= '0;
            hint_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         mapped_ff <= mapped_in;
         dirty_ff  <= dirty_in;
         cnt_ff    <= cnt_in;
         hint_ff   <= hint_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      op_ff     <= op_in;
      kind_ff   <= kind_in;
      ord_ff    <= ord_in;
      k_ff      <= k_in;
      bk_ff     <= bk_in;
      sk_ff     <= sk_in;
      pn_ff     <= pn_in;
      page_ff   <= page_in;
      idx_ff    <= idx_in;
      bi_ff     <= bi_in;
      used_ff   <= used_in;
      status_ff <= status_in;
      fill_ff   <= fill_in;
      sw_ff     <= sw_in;
   end

   // result beat
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_status      = status_ff;
   assign rsp_result_page = page_ff;
   assign rsp_avail_pages = RPAGES_W'(total_ff);
   assign rsp_region_full = (total_ff == '0);

`ifndef ASSERT_OFF
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_fail_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_result_page == '0))
      else $error("failed item returned a page");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (total_ff <= mapped_ff))
      else $error("free page count above mapped pages");
`endif

endmodule

>>> sim/buddy_page_allocator_test.sv
// Self-checking testbench for the buddy page allocator.
`timescale 1ns / 1ps

import bpa_pkg::*;

typedef struct {
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   page;
   logic [RPAGES_W-1:0] avail_pages;
   logic                full;
} alloc_rsp_t;

// Buddy map predictor plus the queue of responses it expects
class buddy_map_sb;
   localparam int ORDERS = DEF_NUM_ORDERS;
   localparam int PAGES  = DEF_MAX_PAGES;
   localparam int TOP    = ORDERS - 1;

   bit          used_bm [ORDERS][PAGES];
   int unsigned free_cnt [ORDERS];
   int unsigned low_hint [ORDERS];
   int unsigned free_total;
   int unsigned mapped;
   logic [PAGE_W-1:0]   base_page;
   logic [RPAGES_W-1:0] span_pages;
   alloc_rsp_t  pending_rsp[$];
   int          mismatches;

   function new();
      foreach (used_bm[k, i]) used_bm[k][i] = 1'b1;
      foreach (free_cnt[k]) begin
         free_cnt[k] = 0;
         low_hint[k] = 0;
      end
      free_total = 0;
      mapped     = 0;
      base_page  = '0;
      span_pages = '0;
      mismatches = 0;
   endfunction

   function void write_csr(csr_type idx, logic [PAGE_W-1:0] val);
      if (idx == CSR_BASE) base_page = val;
      else span_pages = val[RPAGES_W-1:0];
   endfunction

   function bit is_used(int unsigned k, int unsigned i);
      if (k >= ORDERS || i >= (mapped >> k) || i >= PAGES) return 1'b1;
      return used_bm[k][i];
   endfunction

   function void take(int unsigned k, int unsigned i);
      if (is_used(k, i)) return;
      used_bm[k][i] = 1'b1;
      free_cnt[k]--;
   endfunction

   function void give(int unsigned k, int unsigned i);
      if (!is_used(k, i) || k >= ORDERS || i >= (mapped >> k)) return;
      used_bm[k][i] = 1'b0;
      free_cnt[k]++;
   endfunction

   // lowest order above ord whose block holding idx is free, 0 when none
   function int unsigned free_parent(int unsigned ord, int unsigned idx);
      for (int unsigned a = ord + 1; a < ORDERS; a++)
         if (!is_used(a, idx >> (a - ord))) return a;
      return 0;
   endfunction

   function bit block_index(logic [PAGE_W-1:0] pn, int unsigned ord,
                            output int unsigned idx);
      logic [63:0] off;
      idx = 0;
      if (pn < base_page) return 1'b0;
      off = 64'(pn) - 64'(base_page);
      if (off >= mapped || (off & ((64'd1 << ord) - 1)) != 0) return 1'b0;
      idx = int'(off >> ord);
      if (idx >= (mapped >> ord)) return 1'b0;
      return 1'b1;
   endfunction

   // Accepted request beat: update the map and queue the response
   function alloc_rsp_t take_request(op_type op, logic [ORDER_W-1:0] ord,
                                     logic [PAGE_W-1:0] pn);
      alloc_rsp_t  r;
      int unsigned j, idx, k, a, room;
      r.status = ST_OK;
      r.page   = '0;
      idx      = 0;
      if (op == OP_INIT) begin
         foreach (used_bm[kk, ii]) used_bm[kk][ii] = 1'b1;
         foreach (free_cnt[kk]) free_cnt[kk] = 0;
         mapped = (span_pages > PAGES) ? PAGES : span_pages;
         for (k = 0; k < TOP; k++)
            if ((mapped >> k) & 1) give(k, (mapped >> k) - 1);
         for (int unsigned i = 0; i < (mapped >> TOP); i++) give(TOP, i);
         free_total = mapped;
      end else if (ord >= ORDERS) begin
         r.status = ST_BAD_ORDER;
      end else if (op == OP_ALLOC) begin
         j = ord;
         while (j < ORDERS && free_cnt[j] == 0) j++;
         if (j >= ORDERS) begin
            r.status = ST_NO_MEM;
         end else begin
            idx = low_hint[j];
            take(j, idx);
            // split down, keeping the lower half
            while (j > ord) begin
               j--;
               idx = idx * 2;
               give(j, idx + 1);
            end
            free_total = ((1 << ord) > free_total) ? 0 : free_total - (1 << ord);
            r.page = base_page + (PAGE_W'(idx) << ord);
         end
      end else if (op == OP_FREE) begin
         if (!block_index(pn, ord, idx) || !is_used(ord, idx) ||
             free_parent(ord, idx) != 0) begin
            r.status = ST_NOT_ALLOC;
         end else begin
            k = ord;
            give(k, idx);
            room = mapped - free_total;
            free_total = ((1 << ord) > room) ? mapped : free_total + (1 << ord);
            // merge free buddies upward
            while (k < TOP && !is_used(k, idx ^ 1)) begin
               take(k, idx);
               take(k, idx ^ 1);
               give(k + 1, idx >> 1);
               idx = idx >> 1;
               k++;
            end
         end
      end else begin
         if (!block_index(pn, ord, idx)) begin
            r.status = ST_NOT_ALLOC;
         end else if (!is_used(ord, idx)) begin
            take(ord, idx);
         end else begin
            a = free_parent(ord, idx);
            if (a == 0) begin
               r.status = ST_NOT_ALLOC;
            end else begin
               take(a, idx >> (a - ord));
               for (j = a; j > ord; j--) give(j - 1, (idx >> (j - 1 - ord)) ^ 1);
            end
         end
         if (r.status == ST_OK) begin
            free_total = ((1 << ord) > free_total) ? 0 : free_total - (1 << ord);
            r.page = pn;
         end
      end
      // hint refresh: lowest free index per order
      for (k = 0; k < ORDERS; k++) begin
         low_hint[k] = 0;
         for (int unsigned i = 0; i < (mapped >> k); i++)
            if (!used_bm[k][i]) begin
               low_hint[k] = i;
               break;
            end
      end
      r.avail_pages = free_total[RPAGES_W-1:0];
      r.full        = (free_total == 0);
      pending_rsp.push_back(r);
      return r;
   endfunction

   function void check_response(alloc_rsp_t got);
      alloc_rsp_t want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: status %0d page %h", got.status, got.page);
         return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status || got.page !== want.page ||
          got.avail_pages !== want.avail_pages || got.full !== want.full) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"response mismatch: exp st %0d pg %h free %0d full %0d,",
                      " got st %0d pg %h free %0d full %0d"},
                     want.status, want.page, want.avail_pages, want.full,
                     got.status, got.page, got.avail_pages, got.full);
      end
   endfunction
endclass

module buddy_page_allocator_test;
   localparam int LIMIT = 8_000_000;

   typedef struct {
      logic [PAGE_W-1:0]  page;
      logic [ORDER_W-1:0] ord;
   } held_block_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_op = '0;
   logic [ORDER_W-1:0]  req_order = '0;
   logic [PAGE_W-1:0]   req_page_number = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [PAGE_W-1:0]   rsp_result_page;
   logic [RPAGES_W-1:0] rsp_avail_pages;
   logic                rsp_region_full;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [PAGE_W-1:0]   csr_wdata = '0;

   buddy_map_sb   sb = new();
   held_block_t   held[$];
   longint        cycles = 0;

   buddy_page_allocator u_dut (
      .clock, .reset, .start, .busy, .req_op, .req_order, .req_page_number,
      .rsp_valid, .rsp_status, .rsp_result_page, .rsp_avail_pages,
      .rsp_region_full, .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response monitor
   always @(posedge clock) begin
      alloc_rsp_t got;
      if (!reset && rsp_valid) begin
         got.status      = rsp_status;
         got.page        = rsp_result_page;
         got.avail_pages = rsp_avail_pages;
         got.full        = rsp_region_full;
         sb.check_response(got);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one request beat, with a random lead-in gap
   task automatic send(op_type op, logic [ORDER_W-1:0] ord, logic [PAGE_W-1:0] pn);
      int unsigned gap;
      alloc_rsp_t  r;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_op          <= op;
      req_order       <= ord;
      req_page_number <= pn;
      do @(posedge clock); while (busy);
      r = sb.take_request(op, ord, pn);
      if (op == OP_INIT) held.delete();
      else if (r.status == ST_OK && (op == OP_ALLOC || op == OP_RESERVE))
         held.push_back('{page: r.page, ord: ord});
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one write beat, then csr_we is dropped before returning so back-to-back writes never collide
   task automatic write_reg(csr_type idx, logic [PAGE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_csr(idx, val);
      @(posedge clock);
   endtask

   function automatic logic [PAGE_W-1:0] rand_page();
      return PAGE_W'({$urandom(), $urandom()});
   endfunction

   // mostly legal orders, now and then a bad one
   function automatic logic [ORDER_W-1:0] pick_order();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return ORDER_W'($urandom_range(0, 3));
      if (r < 95) return ORDER_W'($urandom_range(0, 10));
      return ORDER_W'($urandom_range(11, 15));
   endfunction

   task automatic random_beat();
      int unsigned        r, n;
      logic [ORDER_W-1:0] ord;
      logic [63:0]        off;
      held_block_t        b;
      r   = $urandom_range(0, 99);
      ord = pick_order();
      if (r < 2) begin
         send(OP_INIT, ord, rand_page());
      end else if (r < 45) begin
         send(OP_ALLOC, ord, rand_page());
      end else if (r < 80) begin
         if (held.size() != 0 && $urandom_range(0, 99) < 85) begin
            n = $urandom_range(0, held.size() - 1);
            b = held[n];
            held.delete(n);
            send(OP_FREE, b.ord, b.page);
         end else begin
            send(OP_FREE, ord, rand_page());
         end
      end else begin
         if (sb.mapped != 0 && ord < 11 && $urandom_range(0, 99) < 70) begin
            off = 64'($urandom_range(0, sb.mapped - 1));
            off = off & ~((64'd1 << ord) - 1);
            send(OP_RESERVE, ord, sb.base_page + PAGE_W'(off));
         end else begin
            send(OP_RESERVE, ord, rand_page());
         end
      end
   endtask

   initial begin
      logic [PAGE_W-1:0] phase_base [8];
      logic [PAGE_W-1:0] phase_span [8];
      held_block_t       b;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nothing mapped yet
      send(OP_ALLOC, 4'd0, '0);
      send(OP_FREE, 4'd0, '0);
      send(OP_RESERVE, 4'd0, '0);
      drain();

      // oversized region saturates, base offset exercises the below-base case
      write_reg(CSR_BASE, 36'h100);
      write_reg(CSR_PAGES, 36'h1FFF);
      send(OP_INIT, 4'd0, '0);
      send(OP_ALLOC, 4'd0, '0);
      send(OP_ALLOC, 4'd10, '0);
      send(OP_ALLOC, 4'd15, '0);
      send(OP_FREE, 4'd15, 36'h100);
      send(OP_RESERVE, 4'd11, 36'h100);
      send(OP_FREE, 4'd0, 36'h0);
      send(OP_FREE, 4'd1, 36'h101);
      send(OP_FREE, 4'd0, 36'h900);
      send(OP_RESERVE, 4'd0, 36'h905);
      send(OP_RESERVE, 4'd0, 36'h905);
      send(OP_RESERVE, 4'd3, 36'h1100);
      send(OP_FREE, 4'd0, 36'h905);
      send(OP_FREE, 4'd0, 36'h100);
      send(OP_FREE, 4'd0, 36'h100);
      send(OP_FREE, 4'd0, 36'hF_FFFF_FFFF);
      send(OP_RESERVE, 4'd10, 36'h100);
      send(OP_ALLOC, 4'd10, '0);
      send(OP_ALLOC, 4'd10, '0);
      send(OP_ALLOC, 4'd10, '0);
      send(OP_ALLOC, 4'd0, '0);
      while (held.size() != 0) begin
         b = held.pop_front();
         send(OP_FREE, b.ord, b.page);
      end
      drain();

      // random phases over several region settings
      phase_base = '{36'h0, 36'hF_FFFF_FC00, 36'hF_FFFF_FFFF, rand_page(),
                     rand_page(), 36'h0, rand_page(), rand_page()};
      phase_span = '{36'd4096, 36'd1500, 36'd1, 36'd0, 36'h1FFF, 36'd37,
                     36'(($urandom_range(2, 4096))), 36'd4095};
      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_BASE, phase_base[p]);
         write_reg(CSR_PAGES, phase_span[p]);
         send(OP_INIT, 4'd0, '0);
         for (int i = 0; i < 205; i++) begin
            random_beat();
            if (p == 3 && i == 100) drain();
         end
         drain();
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
